/* sv/gba_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gba_pkg
// Shared constants, types and helpers for the growable bitmap allocator.
// ----------------------------------------------------------------------------
package gba_pkg;

    localparam int CAPACITY_BITS = 4096;
    localparam int BYTE_BITS     = 8;
    localparam int STORE_BYTES   = (CAPACITY_BITS + BYTE_BITS - 1) / BYTE_BITS;
    localparam int ADDR_W        = $clog2(STORE_BYTES);
    localparam int POS_W         = $clog2(BYTE_BITS);
    localparam int IDX_W         = 12;
    localparam int LEN_W         = 13;
    localparam int LEN_RESET     = 256;

    typedef enum logic [1:0] {
        OP_WRITE = 2'd0,
        OP_READ  = 2'd1,
        OP_FIND  = 2'd2,
        OP_NONE  = 2'd3
    } gba_op_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_SCAN
    } gba_state_t;

    typedef struct packed {
        logic                 en;
        logic [ADDR_W-1:0]    addr;
        logic [BYTE_BITS-1:0] data;
    } gba_wr_t;

    // position of the lowest zero bit, BYTE_BITS when the byte is all ones
    function automatic logic [POS_W:0] lowest_zero(input logic [BYTE_BITS-1:0] b);
        logic [POS_W:0] p;
        p = (POS_W+1)'(BYTE_BITS);
        for (int k = BYTE_BITS - 1; k >= 0; k--)
        begin
            if (!b[k])
            begin
                p = (POS_W+1)'(k);
            end
        end
        return p;
    endfunction

endpackage

/* sv/gba_store.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gba_store
// Byte-wide bit map memory with one write and one registered read port,
// plus a clearing sweep after reset and on request.
// ----------------------------------------------------------------------------
module gba_store (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          clear_start,
    input  gba_pkg::gba_wr_t              wr,
    input  logic [gba_pkg::ADDR_W-1:0]    rd_addr,
    output logic [gba_pkg::BYTE_BITS-1:0] rd_data,
    output logic                          clear_busy
);
    import gba_pkg::*;

    logic [BYTE_BITS-1:0] mem [STORE_BYTES];
    logic                 clr_busy_reg;
    logic                 clr_busy_next;
    logic [ADDR_W-1:0]    clr_cnt_reg;
    logic [ADDR_W-1:0]    clr_cnt_next;
    logic                 mem_we;
    logic [ADDR_W-1:0]    mem_waddr;
    logic [BYTE_BITS-1:0] mem_wdata;

    always_comb
    begin
        clr_busy_next = clr_busy_reg;
        clr_cnt_next  = clr_cnt_reg;
        if (clear_start)
        begin
            clr_busy_next = 1'b1;
            clr_cnt_next  = '0;
        end
        else if (clr_busy_reg)
        begin
            clr_cnt_next  = clr_cnt_reg + ADDR_W'(1);
            clr_busy_next = (clr_cnt_reg != ADDR_W'(STORE_BYTES - 1));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_busy_reg <= 1'b1;
            clr_cnt_reg  <= '0;
        end
        else
        begin
            clr_busy_reg <= clr_busy_next;
            clr_cnt_reg  <= clr_cnt_next;
        end
    end

    always_comb
    begin
        if (clr_busy_reg)
        begin
            mem_we    = 1'b1;
            mem_waddr = clr_cnt_reg;
            mem_wdata = '0;
        end
        else
        begin
            mem_we    = wr.en;
            mem_waddr = wr.addr;
            mem_wdata = wr.data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        rd_data <= mem[rd_addr];
    end

    assign clear_busy = clr_busy_reg;

endmodule

/* sv/growable_bitmap_allocator.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// growable_bitmap_allocator
// Write and read go through a byte read-modify-write with forwarding and can
// be accepted back to back, one a cycle, while the output is not stalled.
// Find reads one byte at a time from the hint through the single memory read
// port, skipping all-ones bytes. After reset and after a length write the
// store is cleared byte by byte, and no request is accepted until it is done.
// ----------------------------------------------------------------------------
module growable_bitmap_allocator (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [gba_pkg::LEN_W-1:0]   initial_length,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic [1:0]                  opcode,
    input  logic [gba_pkg::IDX_W-1:0]   bit_index,
    input  logic                        write_value,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic                        status,
    output logic                        read_bit,
    output logic [gba_pkg::IDX_W-1:0]   found_index,
    output logic [gba_pkg::LEN_W-1:0]   bits_in_use
);
    import gba_pkg::*;

    gba_state_t           state_reg, state_next;
    logic [1:0]           op_reg;
    logic [IDX_W-1:0]     idx_reg;
    logic                 wv_reg;
    logic [ADDR_W:0]      cur_reg, cur_next;
    logic [ADDR_W-1:0]    addr_reg;
    logic [LEN_W-1:0]     length_reg, length_next;
    logic [ADDR_W-1:0]    hint_reg, hint_next;
    logic                 fwd_valid_reg;
    logic [ADDR_W-1:0]    fwd_addr_reg;
    logic [BYTE_BITS-1:0] fwd_data_reg;
    logic                 out_valid_reg;
    logic                 status_reg;
    logic                 read_bit_reg;
    logic [IDX_W-1:0]     found_reg;
    logic [LEN_W-1:0]     len_out_reg;

    gba_wr_t              wr;
    logic [ADDR_W-1:0]    rd_addr;
    logic [BYTE_BITS-1:0] rd_data;
    logic                 clear_busy;
    logic [BYTE_BITS-1:0] byte_eff;
    logic [BYTE_BITS-1:0] new_byte;
    logic [BYTE_BITS-1:0] part_byte;
    logic [BYTE_BITS-1:0] part_mask;
    logic [ADDR_W:0]      full_bytes;
    logic [POS_W-1:0]     rem_bits;
    logic [POS_W:0]       zpos;
    logic [IDX_W-1:0]     cand;
    logic                 finish;
    logic                 out_free;
    logic                 done;
    logic                 accept;
    logic                 res_status;
    logic                 res_rbit;
    logic [IDX_W-1:0]     res_found;
    logic [LEN_W-1:0]     res_len;
    logic [LEN_W-1:0]     len_calc;
    logic [ADDR_W-1:0]    hint_calc;
    logic [LEN_W-1:0]     cfg_len;

    gba_store u_store (
        .clk         (clk),
        .rst_n       (rst_n),
        .clear_start (cfg_valid),
        .wr          (wr),
        .rd_addr     (rd_addr),
        .rd_data     (rd_data),
        .clear_busy  (clear_busy)
    );

    assign cfg_ready  = 1'b1;
    assign byte_eff   = (fwd_valid_reg && (fwd_addr_reg == addr_reg)) ? fwd_data_reg : rd_data;
    assign full_bytes = length_reg[LEN_W-1:POS_W];
    assign rem_bits   = length_reg[POS_W-1:0];
    assign part_mask  = BYTE_BITS'((9'd1 << rem_bits) - 9'd1);
    assign part_byte  = byte_eff & part_mask;
    assign out_free   = !out_valid_reg || !out_stall;
    assign cfg_len    = (initial_length > LEN_W'(CAPACITY_BITS)) ? LEN_W'(CAPACITY_BITS)
                                                                 : initial_length;

    always_comb
    begin
        state_next = state_reg;
        cur_next   = cur_reg;
        length_next = length_reg;
        hint_next  = hint_reg;
        rd_addr    = addr_reg;
        wr         = '0;
        new_byte   = byte_eff;
        finish     = 1'b0;
        res_status = 1'b0;
        res_rbit   = 1'b0;
        res_found  = '0;
        len_calc   = length_reg;
        hint_calc  = hint_reg;
        zpos       = '0;
        cand       = '0;

        case (state_reg)
            ST_IDLE:
            begin
                finish = 1'b0;
            end
            ST_EXEC:
            begin
                finish = 1'b1;
                case (op_reg)
                    OP_WRITE:
                    begin
                        new_byte[idx_reg[POS_W-1:0]] = wv_reg;
                        if ({1'b0, idx_reg} >= length_reg)
                        begin
                            len_calc = {1'b0, idx_reg} + LEN_W'(1);
                        end
                        if (!wv_reg && (idx_reg[IDX_W-1:POS_W] < hint_reg))
                        begin
                            hint_calc = idx_reg[IDX_W-1:POS_W];
                        end
                        wr.en   = out_free;
                        wr.addr = idx_reg[IDX_W-1:POS_W];
                        wr.data = new_byte;
                    end
                    OP_READ:
                    begin
                        if ({1'b0, idx_reg} < length_reg)
                        begin
                            res_rbit = byte_eff[idx_reg[POS_W-1:0]];
                        end
                    end
                    default:
                    begin
                        res_rbit = 1'b0;
                    end
                endcase
            end
            ST_SCAN:
            begin
                if ((cur_reg < full_bytes) && (byte_eff == {BYTE_BITS{1'b1}}))
                begin
                    cur_next  = cur_reg + (ADDR_W+1)'(1);
                    rd_addr   = cur_next[ADDR_W-1:0];
                end
                else
                begin
                    finish = 1'b1;
                    if (cur_reg < full_bytes)
                    begin
                        zpos      = lowest_zero(byte_eff);
                        hint_calc = cur_reg[ADDR_W-1:0];
                        res_found = {cur_reg[ADDR_W-1:0], zpos[POS_W-1:0]};
                    end
                    else if ((rem_bits != '0) && !cur_reg[ADDR_W])
                    begin
                        zpos      = lowest_zero(part_byte);
                        cand      = {cur_reg[ADDR_W-1:0], zpos[POS_W-1:0]};
                        hint_calc = cur_reg[ADDR_W-1:0];
                        res_found = cand;
                        if ({1'b0, cand} >= length_reg)
                        begin
                            len_calc = {1'b0, cand} + LEN_W'(1);
                        end
                    end
                    else if (length_reg >= LEN_W'(CAPACITY_BITS))
                    begin
                        res_status = 1'b1;
                    end
                    else
                    begin
                        res_found = length_reg[IDX_W-1:0];
                        len_calc  = length_reg + LEN_W'(1);
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        res_len = len_calc;
        done    = finish && out_free;
        if (done)
        begin
            length_next = len_calc;
            hint_next   = hint_calc;
            state_next  = ST_IDLE;
        end

        in_stall = clear_busy || !((state_reg == ST_IDLE) || done);
        accept   = in_valid && !in_stall;
        if (accept)
        begin
            if (opcode == OP_FIND)
            begin
                state_next = ST_SCAN;
                rd_addr    = hint_next;
                cur_next   = {1'b0, hint_next};
            end
            else
            begin
                state_next = ST_EXEC;
                rd_addr    = bit_index[IDX_W-1:POS_W];
            end
        end

        if (cfg_valid)
        begin
            length_next = cfg_len;
            hint_next   = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            length_reg    <= LEN_W'(LEN_RESET);
            hint_reg      <= '0;
            fwd_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            length_reg    <= length_next;
            hint_reg      <= hint_next;
            fwd_valid_reg <= wr.en;
            if (done)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        addr_reg     <= rd_addr;
        cur_reg      <= cur_next;
        fwd_addr_reg <= wr.addr;
        fwd_data_reg <= wr.data;
        if (accept)
        begin
            op_reg  <= opcode;
            idx_reg <= bit_index;
            wv_reg  <= write_value;
        end
        if (done)
        begin
            status_reg   <= res_status;
            read_bit_reg <= res_rbit;
            found_reg    <= res_found;
            len_out_reg  <= res_len;
        end
    end

    assign out_valid   = out_valid_reg;
    assign status      = status_reg;
    assign read_bit    = read_bit_reg;
    assign found_index = found_reg;
    assign bits_in_use = len_out_reg;

endmodule
